[hdl/cfw_pkg.sv]
package cfw_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [0:0] {
		REG_FIRST_SYNC  = 1'b0,
		REG_SECOND_SYNC = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_BODY  = 2'd0,
		KIND_OPEN  = 2'd1,
		KIND_CLOSE = 2'd2,
		KIND_SOLO  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_SYNC1 = 3'd1,
		PH_SYNC2 = 3'd2,
		PH_TYPE  = 3'd3,
		PH_LEN   = 3'd4,
		PH_DATA  = 3'd5,
		PH_CRCL  = 3'd6,
		PH_CRCH  = 3'd7
	} phase_t;

	typedef struct packed {
		logic [7:0] frame_type;
		logic [7:0] body_length;
		logic [7:0] data_byte;
		kind_t      kind;
	} item_t;

	typedef struct packed {
		logic [7:0] first_sync;
		logic [7:0] second_sync;
	} sync_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[hdl/crc16_frame_wrapper_core.sv]
// A request accepted into an empty block passes the queue and then the output byte register.
// One output byte per cycle while wire_stall is low, through the single output byte register;
// a body byte that opens a frame adds four header bytes, one that closes it two CRC bytes.
// A four-entry queue between front and back absorbs header and trailer cycles.
// Reset (arst_n low, asynchronous): queue empty, sync bytes 0, CRC 0xFFFF.
module crc16_frame_wrapper_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] frame_type,
	input  logic [7:0] body_length,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	output logic       wire_valid,
	input  logic       wire_stall,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       frame_end,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic           q_full;
	logic           push;
	logic           pop;
	cfw_pkg::item_t push_item;
	cfw_pkg::sync_t sync;
	cfw_pkg::head_t head;

	cfw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.frame_type  (frame_type),
		.body_length (body_length),
		.data_byte   (data_byte),
		.first_byte  (first_byte),
		.last_byte   (last_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item),
		.sync        (sync)
	);

	cfw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.head      (head)
	);

	cfw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.sync       (sync),
		.pop        (pop),
		.wire_valid (wire_valid),
		.wire_stall (wire_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.frame_end  (frame_end)
	);

endmodule

[hdl/cfw_front.sv]
module cfw_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  logic [7:0]          frame_type,
	input  logic [7:0]          body_length,
	input  logic [7:0]          data_byte,
	input  logic                first_byte,
	input  logic                last_byte,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                q_full,
	output logic                push,
	output cfw_pkg::item_t      push_item,
	output cfw_pkg::sync_t      sync
);

	logic [7:0] first_sync_q;
	logic [7:0] second_sync_q;

	assign cfg_ready = 1'b1;
	assign byte_stall = q_full;
	assign push = byte_valid & ~q_full;

	always_comb begin
		push_item.frame_type  = frame_type;
		push_item.body_length = body_length;
		push_item.data_byte   = data_byte;
		unique case ({first_byte, last_byte})
			2'b00: push_item.kind = cfw_pkg::KIND_BODY;
			2'b10: push_item.kind = cfw_pkg::KIND_OPEN;
			2'b01: push_item.kind = cfw_pkg::KIND_CLOSE;
			2'b11: push_item.kind = cfw_pkg::KIND_SOLO;
			default: push_item.kind = cfw_pkg::KIND_BODY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= 8'h00;
			second_sync_q <= 8'h00;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfw_pkg::cfg_reg_t'(cfg_index))
				cfw_pkg::REG_FIRST_SYNC:  first_sync_q  <= cfg_data;
				cfw_pkg::REG_SECOND_SYNC: second_sync_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sync.first_sync  = first_sync_q;
	assign sync.second_sync = second_sync_q;

endmodule

[hdl/cfw_queue.sv]
module cfw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cfw_pkg::item_t push_item,
	input  logic           pop,
	output logic           full,
	output cfw_pkg::head_t head
);

	cfw_pkg::item_t             mem_q [cfw_pkg::QDEPTH];
	logic [cfw_pkg::QAW-1:0]    wr_ptr_q;
	logic [cfw_pkg::QAW-1:0]    rd_ptr_q;
	logic [cfw_pkg::QCW-1:0]    count_q;
	logic                       do_push;
	logic                       do_pop;

	assign full = (count_q == cfw_pkg::QCW'(cfw_pkg::QDEPTH));
	assign do_push = push & ~full;
	assign do_pop = pop & (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/cfw_back.sv]
module cfw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  cfw_pkg::head_t head,
	input  cfw_pkg::sync_t sync,
	output logic           pop,
	output logic           wire_valid,
	input  logic           wire_stall,
	output logic [7:0]     out_byte,
	output logic           run_end,
	output logic           frame_end
);

	cfw_pkg::phase_t phase_q;
	cfw_pkg::phase_t phase_d;
	cfw_pkg::phase_t cur;
	logic [15:0]     crc_q;
	logic [15:0]     crc_d;
	logic            valid_q;
	logic [7:0]      byte_q;
	logic            run_end_q;
	logic            frame_end_q;
	logic            advance;
	logic            opens;
	logic            closes;
	logic [7:0]      byte_d;
	logic            run_end_d;
	logic            frame_end_d;

	assign opens = (head.item.kind == cfw_pkg::KIND_OPEN) ||
		(head.item.kind == cfw_pkg::KIND_SOLO);
	assign closes = (head.item.kind == cfw_pkg::KIND_CLOSE) ||
		(head.item.kind == cfw_pkg::KIND_SOLO);
	assign advance = head.valid & (~valid_q | ~wire_stall);
	assign cur = (phase_q == cfw_pkg::PH_START) ?
		(opens ? cfw_pkg::PH_SYNC1 : cfw_pkg::PH_DATA) : phase_q;

	always_comb begin
		phase_d = phase_q;
		if (advance) begin
			unique case (cur)
				cfw_pkg::PH_SYNC1: phase_d = cfw_pkg::PH_SYNC2;
				cfw_pkg::PH_SYNC2: phase_d = cfw_pkg::PH_TYPE;
				cfw_pkg::PH_TYPE:  phase_d = cfw_pkg::PH_LEN;
				cfw_pkg::PH_LEN:   phase_d = cfw_pkg::PH_DATA;
				cfw_pkg::PH_DATA:  phase_d = closes ? cfw_pkg::PH_CRCL : cfw_pkg::PH_START;
				cfw_pkg::PH_CRCL:  phase_d = cfw_pkg::PH_CRCH;
				cfw_pkg::PH_CRCH:  phase_d = cfw_pkg::PH_START;
				cfw_pkg::PH_START: phase_d = cfw_pkg::PH_START;
				default:           phase_d = cfw_pkg::PH_START;
			endcase
		end
	end

	always_comb begin
		byte_d      = head.item.data_byte;
		run_end_d   = 1'b0;
		frame_end_d = 1'b0;
		crc_d       = crc_q;
		unique case (cur)
			cfw_pkg::PH_SYNC1: begin
				byte_d = sync.first_sync;
				crc_d  = cfw_pkg::CRC_INIT;
			end
			cfw_pkg::PH_SYNC2: byte_d = sync.second_sync;
			cfw_pkg::PH_TYPE: begin
				byte_d = head.item.frame_type;
				crc_d  = cfw_pkg::crc_fold(crc_q, head.item.frame_type);
			end
			cfw_pkg::PH_LEN: begin
				byte_d = head.item.body_length;
				crc_d  = cfw_pkg::crc_fold(crc_q, head.item.body_length);
			end
			cfw_pkg::PH_DATA: begin
				byte_d    = head.item.data_byte;
				run_end_d = ~closes;
				crc_d     = cfw_pkg::crc_fold(crc_q, head.item.data_byte);
			end
			cfw_pkg::PH_CRCL: byte_d = crc_q[7:0];
			cfw_pkg::PH_CRCH: begin
				byte_d      = crc_q[15:8];
				run_end_d   = 1'b1;
				frame_end_d = 1'b1;
				crc_d       = cfw_pkg::CRC_INIT;
			end
			cfw_pkg::PH_START: byte_d = head.item.data_byte;
			default:           byte_d = head.item.data_byte;
		endcase
	end

	assign pop = advance & run_end_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfw_pkg::PH_START;
			crc_q   <= cfw_pkg::CRC_INIT;
			valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (advance) begin
				crc_q   <= crc_d;
				valid_q <= 1'b1;
			end else if (!wire_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q      <= byte_d;
			run_end_q   <= run_end_d;
			frame_end_q <= frame_end_d;
		end
	end

	assign wire_valid = valid_q;
	assign out_byte   = byte_q;
	assign run_end    = run_end_q;
	assign frame_end  = frame_end_q;

	a_frame_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && frame_end_q |-> run_end_q)
		else $error("frame end without run end");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid && (phase_d == cfw_pkg::PH_START))
		else $error("pop mid item or from empty queue");

	a_crc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cur == cfw_pkg::PH_CRCH) |=> crc_q == cfw_pkg::CRC_INIT)
		else $error("crc not restarted after frame end");

endmodule

[tb/sv/tb_crc16_frame_wrapper_core.sv]
`timescale 1ns / 1ps

module tb_crc16_frame_wrapper_core;

	localparam int ITEMS_PER_PHASE = 28;
	localparam int RAND_PHASES = 5;
	localparam int DIR_ROWS = 15;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX = 10;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY
	} stall_mode_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       frame_end;
	} wire_byte_t;

	typedef struct {
		logic [7:0]      ftype;
		logic [7:0]      blen;
		logic [7:0]      data;
		logic            first;
		logic            last;
		int              n_typed;
		logic [0:4][7:0] wire_seq;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	logic [7:0] frame_type = 8'h00;
	logic [7:0] body_length = 8'h00;
	logic [7:0] data_byte = 8'h00;
	logic       first_byte = 1'b0;
	logic       last_byte = 1'b0;
	logic       wire_valid;
	logic       wire_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_end;
	logic       frame_end;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [0:0] cfg_index = 1'b0;
	logic [7:0] cfg_data = 8'h00;

	logic [7:0]  sync_a = 8'h00;
	logic [7:0]  sync_b = 8'h00;
	logic [15:0] frame_crc = cfw_pkg::CRC_INIT;
	wire_byte_t  step_seq[$];
	wire_byte_t  wire_due[$];

	int burst_left = 0;
	int items_sent = 0;
	int results_seen = 0;
	int frames_closed = 0;
	int mismatches = 0;
	int cycles = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	crc16_frame_wrapper_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.frame_type (frame_type),
		.body_length(body_length),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.wire_valid (wire_valid),
		.wire_stall (wire_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.frame_end  (frame_end),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ cfw_pkg::CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic wire_byte_t wire_byte(input logic [7:0] b, input logic fe);
		wire_byte_t wb;
		wb.out_byte = b;
		wb.run_end = 1'b0;
		wb.frame_end = fe;
		return wb;
	endfunction

	task automatic frame_step(input logic [7:0] ftype, input logic [7:0] blen,
			input logic [7:0] data, input logic first, input logic last);
		step_seq.delete();
		if (first) begin
			frame_crc = cfw_pkg::CRC_INIT;
			step_seq = {step_seq, wire_byte(sync_a, 1'b0)};
			step_seq = {step_seq, wire_byte(sync_b, 1'b0)};
			step_seq = {step_seq, wire_byte(ftype, 1'b0)};
			frame_crc = crc16_modbus_step(frame_crc, ftype);
			step_seq = {step_seq, wire_byte(blen, 1'b0)};
			frame_crc = crc16_modbus_step(frame_crc, blen);
		end
		step_seq = {step_seq, wire_byte(data, 1'b0)};
		frame_crc = crc16_modbus_step(frame_crc, data);
		if (last) begin
			step_seq = {step_seq, wire_byte(frame_crc[7:0], 1'b0)};
			step_seq = {step_seq, wire_byte(frame_crc[15:8], 1'b1)};
			frame_crc = cfw_pkg::CRC_INIT;
		end
		step_seq[step_seq.size() - 1].run_end = 1'b1;
	endtask

	task automatic send_byte(input logic [7:0] ftype, input logic [7:0] blen,
			input logic [7:0] data, input logic first, input logic last,
			input int n_typed, input logic [0:4][7:0] wire_seq);
		int gap;
		wire_byte_t wb;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				byte_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		byte_valid <= 1'b1;
		frame_type <= ftype;
		body_length <= blen;
		data_byte <= data;
		first_byte <= first;
		last_byte <= last;
		do @(posedge clk); while (byte_stall);
		burst_left--;
		items_sent++;
		frame_step(ftype, blen, data, first, last);
		if (n_typed == 0) begin
			wire_due = {wire_due, step_seq};
		end else begin
			for (int k = 0; k < n_typed; k++) begin
				wb = wire_byte(wire_seq[k], 1'b0);
				wb.run_end = (k == n_typed - 1);
				wire_due = {wire_due, wb};
			end
		end
	endtask

	// hold the sender until every pending wire byte has arrived
	task automatic drain_wire();
		@(negedge clk);
		byte_valid <= 1'b0;
		burst_left = 0;
		while (wire_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_sync(input cfw_pkg::cfg_reg_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == cfw_pkg::REG_FIRST_SYNC) begin
			sync_a = val;
		end else begin
			sync_b = val;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic flag(input string what, input logic [7:0] want, input logic [7:0] got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t: %s mismatch: expected %02h, got %02h", $time, what, want, got);
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			stall_left = $urandom_range(16, 80);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE: begin
				wire_stall <= 1'b0;
			end
			STALL_LIGHT: begin
				wire_stall <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				wire_stall <= ($urandom_range(0, 3) != 0);
			end
		endcase
	end

	always @(posedge clk) begin
		wire_byte_t want;
		if (arst_n && wire_valid && !wire_stall) begin
			results_seen++;
			if (frame_end)
				frames_closed++;
			if (wire_due.size() == 0) begin
				flag("unrequested wire byte", 8'hxx, out_byte);
			end else begin
				want = wire_due.pop_front();
				if (out_byte !== want.out_byte)
					flag("out_byte", want.out_byte, out_byte);
				if (run_end !== want.run_end)
					flag("run_end", want.run_end, run_end);
				if (frame_end !== want.frame_end)
					flag("frame_end", want.frame_end, frame_end);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d wire bytes pending", cycles,
				wire_due.size());
			$display("tb_crc16_frame_wrapper_core: done, errors");
			$finish;
		end
	end

	initial begin
		dir_row_t   dir_tab [DIR_ROWS];
		logic [7:0] ftype;
		logic [7:0] blen;
		logic [7:0] new_a;
		logic [7:0] new_b;
		logic       paused;
		int         n;
		int         sent;

		dir_tab = '{
			'{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1, 40'h00_00_00_00_00},
			'{8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 0, 40'h0},
			'{8'h00, 8'h01, 8'h00, 1'b1, 1'b0, 5, 40'h00_00_00_01_00},
			'{8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 1, 40'hFF_00_00_00_00},
			'{8'h00, 8'h00, 8'h5A, 1'b0, 1'b1, 0, 40'h0},
			'{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 0, 40'h0},
			'{8'h00, 8'h01, 8'h00, 1'b1, 1'b1, 0, 40'h0},
			'{8'h12, 8'h03, 8'h34, 1'b1, 1'b0, 5, 40'h00_00_12_03_34},
			'{8'h56, 8'h00, 8'h78, 1'b1, 1'b0, 5, 40'h00_00_56_00_78},
			'{8'h00, 8'h00, 8'h9A, 1'b0, 1'b1, 0, 40'h0},
			'{8'hA5, 8'hFF, 8'h01, 1'b1, 1'b0, 5, 40'h00_00_A5_FF_01},
			'{8'h00, 8'h00, 8'h02, 1'b0, 1'b1, 0, 40'h0},
			'{8'h80, 8'h7F, 8'h80, 1'b1, 1'b1, 0, 40'h0},
			'{8'h00, 8'h00, 8'h01, 1'b0, 1'b0, 1, 40'h01_00_00_00_00},
			'{8'h00, 8'h00, 8'h80, 1'b0, 1'b1, 0, 40'h0}
		};
		paused = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_byte(dir_tab[i].ftype, dir_tab[i].blen, dir_tab[i].data,
				dir_tab[i].first, dir_tab[i].last, dir_tab[i].n_typed,
				dir_tab[i].wire_seq);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_wire();
			case (ph)
				0: begin
					new_a = 8'hFF;
					new_b = 8'hFF;
				end
				1: begin
					new_a = 8'h00;
					new_b = 8'hFF;
				end
				2: begin
					new_a = 8'hFF;
					new_b = 8'h00;
				end
				default: begin
					new_a = 8'($urandom);
					new_b = 8'($urandom);
				end
			endcase
			write_sync(cfw_pkg::REG_FIRST_SYNC, new_a);
			write_sync(cfw_pkg::REG_SECOND_SYNC, new_b);

			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if (ph == 1 && !paused && sent >= ITEMS_PER_PHASE / 2) begin
					drain_wire();
					paused = 1'b1;
				end
				if ($urandom_range(0, 99) < 80) begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
						: $urandom_range(1, 5);
					ftype = 8'($urandom);
					blen = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(n);
					for (int k = 0; k < n; k++)
						send_byte(k == 0 ? ftype : 8'($urandom),
							k == 0 ? blen : 8'($urandom), 8'($urandom),
							k == 0, k == n - 1, 0, '0);
					sent += n;
				end else begin
					send_byte(8'($urandom), 8'($urandom), 8'($urandom),
						1'($urandom), 1'($urandom), 0, '0);
					sent++;
				end
			end
		end

		drain_wire();
		repeat (16) @(posedge clk);

		$display("covered %0d body bytes over %0d directed rows and %0d sync settings",
			items_sent, DIR_ROWS, RAND_PHASES + 1);
		$display("checked %0d wire bytes, %0d frames closed, %0d mismatches",
			results_seen, frames_closed, mismatches);
		if (mismatches == 0) begin
			$display("tb_crc16_frame_wrapper_core: done, clean");
		end else begin
			$display("tb_crc16_frame_wrapper_core: done, errors");
		end
		$finish;
	end

endmodule
